// ----- rtl/nsp_pkg.sv -----
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared widths, state-set codes and the character decode for the packer.
// ----------------------------------------------------------------------------
package nsp_pkg;

   localparam int CHAR_W    = 8;
   localparam int WORD_W    = 32;
   localparam int ROW_LEN_W = 24;
   localparam int SET_W     = 4;

   typedef logic [CHAR_W-1:0]    char_type;
   typedef logic [WORD_W-1:0]    word_type;
   typedef logic [ROW_LEN_W-1:0] row_len_type;
   typedef logic [SET_W-1:0]     set_type;

   // state-set bits
   localparam set_type SET_NONE = 4'h0;
   localparam set_type SET_A    = 4'h1;
   localparam set_type SET_C    = 4'h2;
   localparam set_type SET_G    = 4'h4;
   localparam set_type SET_T    = 4'h8;
   localparam set_type SET_ALL  = 4'hF;

   // accepted characters
   localparam char_type CH_A     = 8'h41;
   localparam char_type CH_C     = 8'h43;
   localparam char_type CH_G     = 8'h47;
   localparam char_type CH_T     = 8'h54;
   localparam char_type CH_U     = 8'h55;
   localparam char_type CH_Y     = 8'h59;
   localparam char_type CH_R     = 8'h52;
   localparam char_type CH_W     = 8'h57;
   localparam char_type CH_S     = 8'h53;
   localparam char_type CH_K     = 8'h4B;
   localparam char_type CH_M     = 8'h4D;
   localparam char_type CH_B     = 8'h42;
   localparam char_type CH_D     = 8'h44;
   localparam char_type CH_H     = 8'h48;
   localparam char_type CH_V     = 8'h56;
   localparam char_type CH_N     = 8'h4E;
   localparam char_type CH_X     = 8'h58;
   localparam char_type CH_QUERY = 8'h3F;
   localparam char_type CH_DASH  = 8'h2D;

   // zero result marks a character that is not allowed
   function automatic set_type decode_symbol(char_type ch);
      set_type set;
      unique case (ch)
         CH_A:     set = SET_A;
         CH_C:     set = SET_C;
         CH_G:     set = SET_G;
         CH_T:     set = SET_T;
         CH_U:     set = SET_T;
         CH_Y:     set = SET_C | SET_T;
         CH_R:     set = SET_A | SET_G;
         CH_W:     set = SET_A | SET_T;
         CH_S:     set = SET_C | SET_G;
         CH_K:     set = SET_G | SET_T;
         CH_M:     set = SET_A | SET_C;
         CH_B:     set = SET_C | SET_G | SET_T;
         CH_D:     set = SET_A | SET_G | SET_T;
         CH_H:     set = SET_A | SET_C | SET_T;
         CH_V:     set = SET_A | SET_C | SET_G;
         CH_N:     set = SET_ALL;
         CH_X:     set = SET_ALL;
         CH_QUERY: set = SET_ALL;
         CH_DASH:  set = SET_ALL;
         default:  set = SET_NONE;
      endcase
      return set;
   endfunction

endpackage

// ----- rtl/nsp_req_if.sv -----
// ----------------------------------------------------------------------------
// nsp_req_if
// Character channel: one alignment character per beat.
// ----------------------------------------------------------------------------
interface nsp_req_if;
   logic               valid;
   logic               ready;
   nsp_pkg::char_type  base_char;

   modport source (output valid, output base_char, input ready);
   modport sink   (input valid, input base_char, output ready);
endinterface

// ----- rtl/nsp_rsp_if.sv -----
// ----------------------------------------------------------------------------
// nsp_rsp_if
// Packed word channel: one packed word with its flags per beat.
// ----------------------------------------------------------------------------
interface nsp_rsp_if;
   logic               valid;
   logic               ready;
   nsp_pkg::word_type  packed_word;
   logic               row_end;
   logic               bad_symbol;

   modport source (output valid, output packed_word, output row_end, output bad_symbol,
                   input ready);
   modport sink   (input valid, input packed_word, input row_end, input bad_symbol,
                   output ready);
endinterface

// ----- rtl/nucleotide_stateset_packer.sv -----
// ----------------------------------------------------------------------------
// nucleotide_stateset_packer
// Packs alignment characters into words of 4-bit nucleotide state sets.
// ----------------------------------------------------------------------------
// path: a completing character goes from the input register to the result register
// throughput: one character per cycle, set by the single decode-and-insert stage,
//   unless a finished word waits on a held result register; a word leaves every
//   NIBBLES_PER_WORD characters or at row end
// reset: synchronous, clears the word, column, nibble and error state and the
//   valid flags; row_length returns to 1
module nucleotide_stateset_packer #(
   parameter int NIBBLES_PER_WORD = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   nsp_req_if.sink                req_bus,
   nsp_rsp_if.source              rsp_bus,
   input  logic                   csr_write_en,
   input  nsp_pkg::row_len_type   csr_write_data
);

   localparam int NIB_POS_W   = $clog2(NIBBLES_PER_WORD);
   localparam int WORD_NIBS   = nsp_pkg::WORD_W / nsp_pkg::SET_W;
   localparam int COL_SUM_W   = nsp_pkg::ROW_LEN_W + 1;

   // row length register
   nsp_pkg::row_len_type row_len_ff;

   // input register
   logic                 s1_valid_ff;
   nsp_pkg::char_type    s1_char_ff;

   // packing state
   nsp_pkg::word_type    acc_ff, acc_in;
   nsp_pkg::row_len_type col_ff, col_in;
   logic [NIB_POS_W-1:0] nib_ff, nib_in;
   logic                 err_ff, err_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   nsp_pkg::word_type    rsp_word_ff;
   logic                 rsp_row_end_ff;
   logic                 rsp_bad_ff;

   // decode and insert
   nsp_pkg::set_type     cur_set;
   logic                 cur_bad;
   logic [COL_SUM_W-1:0] col_next;
   logic                 last_col;
   logic                 word_full;
   logic                 emit;
   nsp_pkg::word_type    word_in;
   logic                 out_room;
   logic                 s1_go;
   logic                 req_beat;

   assign cur_set  = nsp_pkg::decode_symbol(s1_char_ff);
   assign cur_bad  = (cur_set == nsp_pkg::SET_NONE);

   // a column at or past the row length ends the row; zero length ends every column
   assign col_next  = {1'b0, col_ff} + COL_SUM_W'(1);
   assign last_col  = (col_next >= {1'b0, row_len_ff});
   assign word_full = (nib_ff == NIB_POS_W'(NIBBLES_PER_WORD - 1));
   assign emit      = last_col || word_full;

   // insert the new nibble; on row end pad the rest of the word with all-ones,
   // nibbles beyond the 32-bit word are dropped
   always_comb begin
      word_in = acc_ff;
      for (int i = 0; i < WORD_NIBS; i++) begin
         if (i == int'(nib_ff)) begin
            word_in[i*nsp_pkg::SET_W +: nsp_pkg::SET_W] =
               acc_ff[i*nsp_pkg::SET_W +: nsp_pkg::SET_W] | cur_set;
         end else if (last_col && (i > int'(nib_ff)) && (i < NIBBLES_PER_WORD)) begin
            word_in[i*nsp_pkg::SET_W +: nsp_pkg::SET_W] = nsp_pkg::SET_ALL;
         end
      end
   end

   // the stage moves on unless it has a word and the result register is held
   assign out_room  = !rsp_valid_ff || rsp_bus.ready;
   assign s1_go     = s1_valid_ff && (!emit || out_room);
   assign req_bus.ready = !s1_valid_ff || s1_go;
   assign req_beat  = req_bus.valid && req_bus.ready;

   // next packing state
   always_comb begin
      acc_in = acc_ff;
      col_in = col_ff;
      nib_in = nib_ff;
      err_in = err_ff;
      if (s1_go) begin
         if (emit) begin
            acc_in = '0;
            nib_in = '0;
            err_in = 1'b0;
            col_in = last_col ? '0 : col_next[nsp_pkg::ROW_LEN_W-1:0];
         end else begin
            acc_in = word_in;
            nib_in = nib_ff + NIB_POS_W'(1);
            err_in = err_ff || cur_bad;
            col_in = col_next[nsp_pkg::ROW_LEN_W-1:0];
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         row_len_ff   <= nsp_pkg::ROW_LEN_W'(1);
         s1_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         col_ff       <= '0;
         nib_ff       <= '0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            row_len_ff <= csr_write_data;
         end
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         acc_ff       <= acc_in;
         col_ff       <= col_in;
         nib_ff       <= nib_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         s1_char_ff <= req_bus.base_char;
      end
      if (s1_go && emit) begin
         rsp_word_ff    <= word_in;
         rsp_row_end_ff <= last_col;
         rsp_bad_ff     <= err_ff || cur_bad;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.packed_word = rsp_word_ff;
   assign rsp_bus.row_end     = rsp_row_end_ff;
   assign rsp_bus.bad_symbol  = rsp_bad_ff;

   // nibble position stays inside the word
   a_nib_range: assert property (@(posedge clock) disable iff (reset)
      int'(nib_ff) < NIBBLES_PER_WORD)
      else $error("nibble position beyond word");

   // a finished word restarts at nibble zero with a clean error flag
   a_word_restart: assert property (@(posedge clock) disable iff (reset)
      (s1_go && emit) |=> (nib_ff == '0) && !err_ff && (acc_ff == '0))
      else $error("word state not cleared after emit");

   // row end returns the column to zero
   a_row_restart: assert property (@(posedge clock) disable iff (reset)
      (s1_go && last_col) |=> (col_ff == '0))
      else $error("column not cleared at row end");

   // the input side only stalls with a character held in the input register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> (s1_valid_ff && emit && rsp_valid_ff && !rsp_bus.ready))
      else $error("input stalled without a held word");

endmodule

// ----- sim/nsp_word_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nsp_word_checker
// Watches the character and packed word channels, predicts every packed word
// from the accepted characters and the row length, and compares each beat.
// ----------------------------------------------------------------------------
module nsp_word_checker #(
   parameter int NIBBLES = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   nsp_req_if                   req_bus,
   nsp_rsp_if                   rsp_bus,
   input  logic                 csr_write_en,
   input  nsp_pkg::row_len_type csr_write_data,
   output int                   fail_count,
   output int                   words_outstanding
);

   typedef struct packed {
      nsp_pkg::word_type packed_word;
      logic              row_end;
      logic              bad_symbol;
   } word_beat_type;

   word_beat_type        expected_words[$];
   nsp_pkg::row_len_type row_length;
   nsp_pkg::word_type    word_acc;
   int unsigned          column;
   int unsigned          nibble;
   logic                 bad_seen;
   int                   errors = 0;

   assign fail_count = errors;

   // zero marks a character outside the alphabet
   function automatic nsp_pkg::set_type state_set_of(nsp_pkg::char_type ch);
      case (ch)
         nsp_pkg::CH_A:                 return nsp_pkg::SET_A;
         nsp_pkg::CH_C:                 return nsp_pkg::SET_C;
         nsp_pkg::CH_G:                 return nsp_pkg::SET_G;
         nsp_pkg::CH_T, nsp_pkg::CH_U:  return nsp_pkg::SET_T;
         nsp_pkg::CH_Y:                 return nsp_pkg::SET_C | nsp_pkg::SET_T;
         nsp_pkg::CH_R:                 return nsp_pkg::SET_A | nsp_pkg::SET_G;
         nsp_pkg::CH_W:                 return nsp_pkg::SET_A | nsp_pkg::SET_T;
         nsp_pkg::CH_S:                 return nsp_pkg::SET_C | nsp_pkg::SET_G;
         nsp_pkg::CH_K:                 return nsp_pkg::SET_G | nsp_pkg::SET_T;
         nsp_pkg::CH_M:                 return nsp_pkg::SET_A | nsp_pkg::SET_C;
         nsp_pkg::CH_B:
            return nsp_pkg::SET_C | nsp_pkg::SET_G | nsp_pkg::SET_T;
         nsp_pkg::CH_D:
            return nsp_pkg::SET_A | nsp_pkg::SET_G | nsp_pkg::SET_T;
         nsp_pkg::CH_H:
            return nsp_pkg::SET_A | nsp_pkg::SET_C | nsp_pkg::SET_T;
         nsp_pkg::CH_V:
            return nsp_pkg::SET_A | nsp_pkg::SET_C | nsp_pkg::SET_G;
         nsp_pkg::CH_N, nsp_pkg::CH_X, nsp_pkg::CH_QUERY, nsp_pkg::CH_DASH:
            return nsp_pkg::SET_ALL;
         default:                       return nsp_pkg::SET_NONE;
      endcase
   endfunction

   task automatic pack_char(input nsp_pkg::char_type ch);
      nsp_pkg::set_type bases;
      int unsigned      limit;
      logic             last_col;
      logic             word_full;
      bases = state_set_of(ch);
      if (bases == nsp_pkg::SET_NONE)
         bad_seen = 1'b1;
      // nibbles past bit 31 fall off the word
      word_acc |= nsp_pkg::word_type'(bases) << (4 * nibble);
      limit     = (row_length == '0) ? 1 : row_length;
      last_col  = (column + 1) >= limit;
      word_full = (nibble + 1) >= NIBBLES;
      if (!last_col && !word_full) begin
         column = (column + 1) & 32'h00FF_FFFF;
         nibble++;
      end else begin
         if (last_col)
            for (int p = nibble + 1; p < NIBBLES; p++)
               word_acc |= nsp_pkg::word_type'(nsp_pkg::SET_ALL) << (4 * p);
         expected_words.push_back('{word_acc, last_col, bad_seen});
         word_acc = '0;
         nibble   = 0;
         bad_seen = 1'b0;
         column   = last_col ? 0 : ((column + 1) & 32'h00FF_FFFF);
      end
   endtask

   always @(posedge clock) begin : watch
      word_beat_type want;
      if (reset) begin
         expected_words.delete();
         row_length = nsp_pkg::row_len_type'(1);
         word_acc   = '0;
         column     = 0;
         nibble     = 0;
         bad_seen   = 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_words.size() == 0) begin
               errors++;
               $display("%0t: unexpected beat, expected none, actual word %h row_end %b bad %b",
                        $time, rsp_bus.packed_word, rsp_bus.row_end, rsp_bus.bad_symbol);
            end else begin
               want = expected_words.pop_front();
               if (rsp_bus.packed_word !== want.packed_word) begin
                  errors++;
                  $display("%0t: packed_word expected %h actual %h",
                           $time, want.packed_word, rsp_bus.packed_word);
               end
               if (rsp_bus.row_end !== want.row_end) begin
                  errors++;
                  $display("%0t: row_end expected %b actual %b",
                           $time, want.row_end, rsp_bus.row_end);
               end
               if (rsp_bus.bad_symbol !== want.bad_symbol) begin
                  errors++;
                  $display("%0t: bad_symbol expected %b actual %b",
                           $time, want.bad_symbol, rsp_bus.bad_symbol);
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            pack_char(req_bus.base_char);
         if (csr_write_en)
            row_length = csr_write_data;
      end
      words_outstanding <= expected_words.size();
   end

endmodule

// ----- sim/nucleotide_stateset_packer_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nucleotide_stateset_packer_test
// Drives alignment characters and row length settings into the packer with
// random gaps and back-pressure; a checker beside it predicts and compares.
// ----------------------------------------------------------------------------
module nucleotide_stateset_packer_test;

   localparam int NIBBLES        = 8;
   localparam int PHASE_ITEMS    = 80;
   localparam int DRAIN_LIMIT    = 5000;
   localparam int SETTLE_CYCLES  = 4;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_en;
   nsp_pkg::row_len_type csr_write_data;
   int                   fail_count;
   int                   words_outstanding;
   bit                   steady;

   // every character the packer accepts
   nsp_pkg::char_type symbols[19] = '{
      nsp_pkg::CH_A, nsp_pkg::CH_C, nsp_pkg::CH_G, nsp_pkg::CH_T, nsp_pkg::CH_U,
      nsp_pkg::CH_Y, nsp_pkg::CH_R, nsp_pkg::CH_W, nsp_pkg::CH_S, nsp_pkg::CH_K,
      nsp_pkg::CH_M, nsp_pkg::CH_B, nsp_pkg::CH_D, nsp_pkg::CH_H, nsp_pkg::CH_V,
      nsp_pkg::CH_N, nsp_pkg::CH_X, nsp_pkg::CH_QUERY, nsp_pkg::CH_DASH};

   // row lengths per phase: zero (acts as one), exact word multiples, the
   // maximum, and short rows; a long row followed by a short one forces a
   // length change mid-row that the current column already passes
   nsp_pkg::row_len_type row_plan[11] = '{24'd0, 24'd3, 24'd8, 24'hFF_FFFF, 24'd5, 24'd13,
                                          24'd1, 24'd16, 24'd2, 24'd7, 24'd11};

   nsp_req_if req_bus ();
   nsp_rsp_if rsp_bus ();

   nucleotide_stateset_packer #(
      .NIBBLES_PER_WORD (NIBBLES)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   nsp_word_checker #(
      .NIBBLES (NIBBLES)
   ) i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_bus           (req_bus),
      .rsp_bus           (rsp_bus),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data),
      .fail_count        (fail_count),
      .words_outstanding (words_outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly back-to-back, some short gaps, a few long ones; none in steady phases
   function automatic int unsigned gap_cycles();
      int unsigned roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 70)
         return 0;
      if (roll < 93)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // well-formed symbols most of the time, any byte otherwise
   function automatic nsp_pkg::char_type random_char();
      if ($urandom_range(0, 99) < 85)
         return symbols[$urandom_range(0, 18)];
      return nsp_pkg::char_type'($urandom_range(0, 255));
   endfunction

   // one beat on the character channel, then an optional gap; valid stays high
   // across back-to-back beats so it is never lowered and raised in one step
   task automatic send_char(input nsp_pkg::char_type ch);
      int unsigned gap;
      req_bus.valid     <= 1'b1;
      req_bus.base_char <= ch;
      do @(posedge clock); while (!req_bus.ready);
      gap = gap_cycles();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_row_length(input nsp_pkg::row_len_type value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // wait for every predicted word, then let a character still in the
   // pipeline (one that completes no word) clear the two register stages
   task automatic drain();
      int unsigned waited;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (words_outstanding != 0 && waited < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver: ready runs of random length broken by stalls
   initial begin : sink_pacing
      int unsigned stall;
      forever begin
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         stall = gap_cycles();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      nsp_pkg::row_len_type next_len;
      req_bus.valid     <= 1'b0;
      req_bus.base_char <= '0;
      csr_write_en      <= 1'b0;
      csr_write_data    <= '0;
      reset             <= 1'b1;
      steady             = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // row length is 1 out of reset, so each character is a full row:
      // every symbol, then the byte extremes and lower-case letters as bad
      foreach (symbols[i])
         send_char(symbols[i]);
      send_char(8'h00);
      send_char(8'hFF);
      send_char("a");
      send_char("n");
      req_bus.valid <= 1'b0;
      drain();

      // random phases, each under its own row length; the register is written
      // while idle but usually mid-row, so position and word carry over
      for (int phase = 0; phase <= $size(row_plan); phase++) begin
         next_len = (phase < $size(row_plan))
                    ? row_plan[phase]
                    : nsp_pkg::row_len_type'($urandom_range(17, 60));
         write_row_length(next_len);
         steady = (phase % 4 == 3);
         repeat (PHASE_ITEMS)
            send_char(random_char());
         req_bus.valid <= 1'b0;
         drain();
      end

      if (words_outstanding != 0)
         $display("%0t: %0d expected packed words never arrived", $time, words_outstanding);
      if (fail_count == 0 && words_outstanding == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // hard stop well past the slowest correct run
   initial begin : watchdog
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/nsp_pkg.sv
rtl/nsp_req_if.sv
rtl/nsp_rsp_if.sv
rtl/nucleotide_stateset_packer.sv
sim/nsp_word_checker.sv
sim/nucleotide_stateset_packer_test.sv
